// ===== hw/rtl/consensus_unstable_log_window_defines.svh =====
// Assertion macros for the unstable log window block
`ifndef CONSENSUS_UNSTABLE_LOG_WINDOW_DEFINES_SVH
`define CONSENSUS_UNSTABLE_LOG_WINDOW_DEFINES_SVH

`ifndef SYNTHESIS

`define CULW_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define CULW_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`define CULW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define CULW_ASSERT(lbl, clk, rstn, prop, msg)

`define CULW_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)

`define CULW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/culw_pkg.sv =====
// Types, codes and sizes shared by the unstable log window block
`timescale 1ns / 1ps

package culw_pkg;

	localparam int DEPTH  = 64;
	localparam int AW     = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int IDX_W  = 64;
	localparam int TERM_W = 64;
	localparam int CMD_W  = 3;
	localparam int ST_W   = 2;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	localparam logic [CMD_W-1:0] CMD_APPEND      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_STABLE      = 3'd1;
	localparam logic [CMD_W-1:0] CMD_STABLE_SNAP = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RESTORE     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_QUERY       = 3'd4;

	localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
	localparam logic [ST_W-1:0] ST_IGNORED = 2'd1;
	localparam logic [ST_W-1:0] ST_BOUNDS  = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [IDX_W-1:0]  log_index;
		logic [TERM_W-1:0] entry_term;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic              found;
		logic [TERM_W-1:0] found_term;
		logic              first_valid;
		logic [IDX_W-1:0]  first_index;
		logic              last_valid;
		logic [IDX_W-1:0]  last_index;
		logic [CNT_W-1:0]  held_count;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic [AW-1:0]     addr;
		logic [TERM_W-1:0] data;
	} ring_wr_t;

endpackage

// ===== hw/rtl/culw_ram.sv =====
// Term ring: one write port, one registered read port with write bypass
`timescale 1ns / 1ps

module culw_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;
	logic [WIDTH-1:0] byp_q;
	logic             hit_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q  <= mem[raddr];
			byp_q <= wdata;
		end
	end

	// same-edge write to the slot being read: take the new data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (re) begin
			hit_q <= we && (waddr == raddr);
		end
	end

	assign rdata = hit_q ? byp_q : rd_q;

endmodule

// ===== hw/rtl/culw_ctrl.sv =====
// Window state, command decode and result register
`timescale 1ns / 1ps

`include "consensus_unstable_log_window_defines.svh"

module culw_ctrl
	import culw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  req_t              req_s1,
	input  logic [TERM_W-1:0] ring_term,
	output ring_wr_t          ring_wr,
	output logic              done,
	output rsp_t              rsp
);

	logic [IDX_W-1:0]  base_q, base_n;
	logic [CNT_W-1:0]  cnt_q, cnt_n;
	logic              pend_q, pend_n;
	logic [IDX_W-1:0]  snap_idx_q, snap_idx_n;
	logic [TERM_W-1:0] snap_term_q, snap_term_n;
	logic              done_q;
	rsp_t              rsp_q, rsp_n;

	logic [IDX_W-1:0]  idx;
	logic [TERM_W-1:0] term;
	logic [IDX_W-1:0]  diff;
	logic [IDX_W-1:0]  cnt_ext;
	logic              ge;
	logic              in_win;

	always_comb begin
		idx     = req_s1.log_index;
		term    = req_s1.entry_term;
		diff    = idx - base_q;
		cnt_ext = IDX_W'(cnt_q);
		ge      = idx >= base_q;
		in_win  = ge && (diff < cnt_ext);

		base_n      = base_q;
		cnt_n       = cnt_q;
		pend_n      = pend_q;
		snap_idx_n  = snap_idx_q;
		snap_term_n = snap_term_q;
		ring_wr.we   = 1'b0;
		ring_wr.addr = idx[AW-1:0];
		ring_wr.data = term;

		rsp_n            = '0;
		rsp_n.status     = ST_IGNORED;

		unique case (req_s1.command)
			CMD_APPEND: begin
				if (ge && diff == cnt_ext) begin
					if (cnt_q == CNT_FULL) begin
						rsp_n.status = ST_FULL;
					end else begin
						cnt_n        = cnt_q + 1'b1;
						ring_wr.we   = valid_s1;
						rsp_n.status = ST_DONE;
					end
				end else if (!ge || idx == base_q) begin
					base_n       = idx;
					cnt_n        = CNT_W'(1);
					ring_wr.we   = valid_s1;
					rsp_n.status = ST_DONE;
				end else if (diff > cnt_ext) begin
					rsp_n.status = ST_BOUNDS;
				end else begin
					cnt_n        = diff[CNT_W-1:0] + 1'b1;
					ring_wr.we   = valid_s1;
					rsp_n.status = ST_DONE;
				end
			end
			CMD_STABLE: begin
				if (in_win && ring_term == term) begin
					base_n       = idx + 1'b1;
					cnt_n        = cnt_q - (diff[CNT_W-1:0] + 1'b1);
					rsp_n.status = ST_DONE;
				end
			end
			CMD_STABLE_SNAP: begin
				if (pend_q && snap_idx_q == idx) begin
					pend_n       = 1'b0;
					rsp_n.status = ST_DONE;
				end
			end
			CMD_RESTORE: begin
				base_n       = idx + 1'b1;
				cnt_n        = '0;
				pend_n       = 1'b1;
				snap_idx_n   = idx;
				snap_term_n  = term;
				rsp_n.status = ST_DONE;
			end
			CMD_QUERY: begin
				if (!ge) begin
					if (pend_q && snap_idx_q == idx) begin
						rsp_n.found      = 1'b1;
						rsp_n.found_term = snap_term_q;
						rsp_n.status     = ST_DONE;
					end
				end else if (in_win) begin
					rsp_n.found      = 1'b1;
					rsp_n.found_term = ring_term;
					rsp_n.status     = ST_DONE;
				end
			end
			default: ;
		endcase

		rsp_n.first_valid = pend_n;
		rsp_n.first_index = pend_n ? snap_idx_n + 1'b1 : '0;
		rsp_n.held_count  = cnt_n;
		if (cnt_n != '0) begin
			rsp_n.last_valid = 1'b1;
			rsp_n.last_index = base_n + IDX_W'(cnt_n) - 1'b1;
		end else if (pend_n) begin
			rsp_n.last_valid = 1'b1;
			rsp_n.last_index = snap_idx_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			snap_idx_q  <= '0;
			snap_term_q <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1) begin
				base_q      <= base_n;
				cnt_q       <= cnt_n;
				pend_q      <= pend_n;
				snap_idx_q  <= snap_idx_n;
				snap_term_q <= snap_term_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q <= rsp_n;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`CULW_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CNT_FULL, "entry count above ring depth")
	`CULW_ASSERT_NEXT(a_one_result, clk, arst_n, valid_s1, done, "command gave no result beat")
	`CULW_ASSERT_IMPL(a_full_count, clk, arst_n, done && rsp.status == ST_FULL, rsp.held_count == CNT_FULL, "full status with room left")
	`CULW_ASSERT_IMPL(a_first_snap, clk, arst_n, done, rsp.first_valid == pend_q, "first index disagrees with snapshot")
	`CULW_ASSERT_IMPL(a_found_done, clk, arst_n, done && rsp.found, rsp.status == ST_DONE, "found term without done status")

endmodule

// ===== hw/rtl/consensus_unstable_log_window.sv =====
// Top level of the unstable log window block
`timescale 1ns / 1ps

// Takes one command per clock (busy stays low) and gives its result beat on rsp,
// marked by done, once it has passed the valid_s1 and done_q registers. Commands are
// applied in order and each sees the state left by the one before. There is
// no back-pressure on results: the receiver must take done beats as they come.
// The term ring is addressed by the low index bits, so the lookup for a
// command starts at the edge that accepts it; a write from the previous
// command to the same slot is bypassed to the read.

module consensus_unstable_log_window
	import culw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	logic              accept;
	logic              valid_s1;
	req_t              req_s1;
	logic [TERM_W-1:0] ring_term;
	ring_wr_t          ring_wr;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	culw_ram #(
		.DEPTH(DEPTH),
		.WIDTH(TERM_W)
	) u_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (ring_wr.we),
		.waddr (ring_wr.addr),
		.wdata (ring_wr.data),
		.re    (accept),
		.raddr (req.log_index[AW-1:0]),
		.rdata (ring_term)
	);

	culw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1),
		.ring_term(ring_term),
		.ring_wr  (ring_wr),
		.done     (done),
		.rsp      (rsp)
	);

endmodule
